>>> hw/rtl/letterbox_resize_quantize_top_assert.svh
// Assertion macros for the letterbox resize and quantize block
`ifndef LETTERBOX_RESIZE_QUANTIZE_TOP_ASSERT_SVH
`define LETTERBOX_RESIZE_QUANTIZE_TOP_ASSERT_SVH

// same-cycle implication on clk, masked during reset
`define LRQ_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication on clk, masked during reset
`define LRQ_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> hw/rtl/lrq_pkg.sv
// Shared types and constants for the letterbox resize and quantize block
`timescale 1ns / 1ps
package lrq_pkg;

	typedef struct packed {
		logic        command;
		logic [16:0] src_address;
		logic [15:0] pixel_value;
		logic [13:0] out_index;
	} item_t;

	typedef struct packed {
		logic signed [7:0] red_q;
		logic signed [7:0] green_q;
		logic signed [7:0] blue_q;
		logic              is_padding;
	} result_t;

	// fitted geometry, derived from the source size
	typedef struct packed {
		logic [8:0] w;
		logic [7:0] h;
		logic       sel_h;
		logic [8:0] den;
		logic [8:0] fit_w;
		logic [8:0] fit_h;
		logic [7:0] off_x;
		logic [7:0] off_y;
	} geom_t;

	// frame store access
	typedef struct packed {
		logic        vld;
		logic        wr;
		logic        pad;
		logic [16:0] addr;
		logic [15:0] wdata;
	} acc_t;

	// frame store read beat
	typedef struct packed {
		logic        vld;
		logic        pad;
		logic [15:0] pix;
	} rd_t;

	typedef enum logic [1:0] {
		REG_SRC_WIDTH   = 2'd0,
		REG_SRC_HEIGHT  = 2'd1,
		REG_QUANT_GAIN  = 2'd2,
		REG_ZERO_OFFSET = 2'd3
	} reg_idx_t;

	localparam logic [8:0]  SRC_WIDTH_RST   = 9'd320;
	localparam logic [7:0]  SRC_HEIGHT_RST  = 8'd240;
	localparam logic [23:0] QUANT_GAIN_RST  = 24'd65793;
	localparam logic [7:0]  ZERO_OFFSET_RST = 8'd0;

	localparam logic [4:0]  DIV_STEPS  = 5'd17;
	localparam int unsigned IDX_SHIFT  = 22;
	localparam int unsigned SCL_SHIFT  = 25;
	localparam logic [32:0] ROUND_BIAS = 33'd65536;

endpackage

>>> hw/rtl/letterbox_resize_quantize_top.sv
// Top level of the letterbox resize and quantize block
//
//  channel   direction  handshake                  beat
//  item      in         item_valid / item_ready    item_t: write pixel or read output pixel
//  result    out        result_valid/result_ready  result_t: three int8 channels, padding flag
//  config    in         psel/penable/pwrite, APB   4 registers at 0x0, 0x4, 0x8, 0xC
//
// One item a cycle while item_ready is high; reads go via map, store, quantizer and skid.
// The frame store has one port, so writes and reads share it in beat order.
// After reset, and after each write of src_width or src_height, item_ready holds low while
// the fit unit divides out the letterbox (one quotient bit a cycle).
// A two-entry output skid keeps item_ready registered; a full skid stalls the whole pipe.
`timescale 1ns / 1ps
module letterbox_resize_quantize_top import lrq_pkg::*; #(
	parameter int unsigned OUT_WIDTH      = 96,
	parameter int unsigned OUT_HEIGHT     = 96,
	parameter int unsigned MAX_SRC_WIDTH  = 320,
	parameter int unsigned MAX_SRC_HEIGHT = 240
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

	// configuration registers
	logic [8:0]        src_width_q;
	logic [7:0]        src_height_q;
	logic [23:0]       quant_gain_q;
	logic signed [7:0] zero_offset_q;

	reg_idx_t reg_idx;
	logic     cfg_wr;
	logic     fit_start;
	logic     busy;
	geom_t    geom;

	logic    en;
	logic    accept;
	acc_t    acc;
	rd_t     rd;
	logic    res_vld;
	result_t res;

	// output skid
	logic    out_v_q;
	result_t out_d_q;
	logic    sp_v_q;
	result_t sp_d_q;
	logic    push;
	logic    pop;

	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[3:2]);
	assign cfg_wr    = psel && penable && pwrite;
	assign fit_start = cfg_wr && (reg_idx == REG_SRC_WIDTH || reg_idx == REG_SRC_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q   <= SRC_WIDTH_RST;
			src_height_q  <= SRC_HEIGHT_RST;
			quant_gain_q  <= QUANT_GAIN_RST;
			zero_offset_q <= ZERO_OFFSET_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SRC_WIDTH:   src_width_q   <= pwdata[8:0];
				REG_SRC_HEIGHT:  src_height_q  <= pwdata[7:0];
				REG_QUANT_GAIN:  quant_gain_q  <= pwdata[23:0];
				REG_ZERO_OFFSET: zero_offset_q <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SRC_WIDTH:   prdata = 32'(src_width_q);
			REG_SRC_HEIGHT:  prdata = 32'(src_height_q);
			REG_QUANT_GAIN:  prdata = 32'(quant_gain_q);
			REG_ZERO_OFFSET: prdata = 32'(unsigned'(zero_offset_q));
			default:         prdata = '0;
		endcase
	end

	// advance the pipe whenever the skid spare slot is empty
	assign en         = !sp_v_q;
	assign item_ready = en && !busy;
	assign accept     = item_valid && item_ready;

	lrq_fit #(
		.OUT_WIDTH(OUT_WIDTH),
		.OUT_HEIGHT(OUT_HEIGHT),
		.MAX_SRC_WIDTH(MAX_SRC_WIDTH),
		.MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)
	) u_fit (
		.clk(clk),
		.arst_n(arst_n),
		.start(fit_start),
		.src_width(src_width_q),
		.src_height(src_height_q),
		.busy(busy),
		.geom(geom)
	);

	lrq_map #(
		.OUT_WIDTH(OUT_WIDTH),
		.OUT_HEIGHT(OUT_HEIGHT),
		.MAX_SRC_WIDTH(MAX_SRC_WIDTH),
		.MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)
	) u_map (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(accept),
		.item(item),
		.geom(geom),
		.acc(acc)
	);

	lrq_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.acc(acc),
		.rd(rd)
	);

	lrq_quant u_quant (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.rd(rd),
		.gain(quant_gain_q),
		.zp(zero_offset_q),
		.res_vld(res_vld),
		.res(res)
	);

	// a result leaves the quantizer at each advancing edge that carries one
	assign push = en && res_vld;
	assign pop  = out_v_q && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sp_v_q  <= 1'b0;
		end else if (pop || !out_v_q) begin
			if (sp_v_q) begin
				out_v_q <= 1'b1;
				sp_v_q  <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			sp_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_v_q) begin
			if (sp_v_q) begin
				out_d_q <= sp_d_q;
			end else if (push) begin
				out_d_q <= res;
			end
		end else if (push) begin
			sp_d_q <= res;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_d_q;

endmodule

>>> hw/rtl/lrq_fit.sv
// Fit geometry unit: saturates the source size and divides out the letterbox
`timescale 1ns / 1ps
module lrq_fit import lrq_pkg::*; #(
	parameter int unsigned OUT_WIDTH      = 96,
	parameter int unsigned OUT_HEIGHT     = 96,
	parameter int unsigned MAX_SRC_WIDTH  = 320,
	parameter int unsigned MAX_SRC_HEIGHT = 240
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [8:0] src_width,
	input  logic [7:0] src_height,
	output logic       busy,
	output geom_t      geom
);

	typedef enum logic [3:0] {
		ST_LOAD = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_DONE = 4'b0100,
		ST_IDLE = 4'b1000
	} fit_state_t;

	fit_state_t  state_q;
	logic [4:0]  cnt_q;
	logic [8:0]  w_q;
	logic [7:0]  h_q;
	logic        sel_q;
	logic [8:0]  dvs_q;
	logic [16:0] quo_q;
	logic [8:0]  rem_q;
	geom_t       geom_q;

	logic [8:0]  w_sat;
	logic [7:0]  h_sat;
	logic [17:0] cmp_w;
	logic [17:0] cmp_h;
	logic        sel_c;
	logic [9:0]  trial;
	logic [9:0]  diff;
	logic        ge;
	logic [8:0]  fq_w;
	logic [8:0]  fq_h;
	logic [8:0]  fw;
	logic [8:0]  fh;

	always_comb begin
		w_sat = src_width;
		if (src_width == '0) begin
			w_sat = 9'd1;
		end else if (32'(src_width) > MAX_SRC_WIDTH) begin
			w_sat = 9'(MAX_SRC_WIDTH);
		end
		h_sat = src_height;
		if (src_height == '0) begin
			h_sat = 8'd1;
		end else if (32'(src_height) > MAX_SRC_HEIGHT) begin
			h_sat = 8'(MAX_SRC_HEIGHT);
		end
		cmp_w = 18'(OUT_HEIGHT) * 18'(w_sat);
		cmp_h = 18'(OUT_WIDTH) * 18'(h_sat);
		sel_c = cmp_h > cmp_w;
	end

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, quo_q[16]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_comb begin
		fq_w = (32'(quo_q) > OUT_WIDTH) ? 9'(OUT_WIDTH) : quo_q[8:0];
		fq_h = (32'(quo_q) > OUT_HEIGHT) ? 9'(OUT_HEIGHT) : quo_q[8:0];
		fw   = sel_q ? fq_w : 9'(OUT_WIDTH);
		fh   = sel_q ? 9'(OUT_HEIGHT) : fq_h;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
		end else if (start) begin
			state_q <= ST_LOAD;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					state_q <= ST_DIV;
					cnt_q   <= DIV_STEPS;
				end
				ST_DIV: begin
					if (cnt_q == 5'd1) begin
						state_q <= ST_DONE;
					end
					cnt_q <= cnt_q - 5'd1;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			w_q   <= w_sat;
			h_q   <= h_sat;
			sel_q <= sel_c;
			dvs_q <= sel_c ? {1'b0, h_sat} : w_sat;
			quo_q <= sel_c ? cmp_w[16:0] : cmp_h[16:0];
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			quo_q <= {quo_q[15:0], ge};
			rem_q <= ge ? diff[8:0] : trial[8:0];
		end else if (state_q == ST_DONE) begin
			geom_q.w     <= w_q;
			geom_q.h     <= h_q;
			geom_q.sel_h <= sel_q;
			geom_q.den   <= dvs_q;
			geom_q.fit_w <= fw;
			geom_q.fit_h <= fh;
			geom_q.off_x <= 8'((9'(OUT_WIDTH) - fw) >> 1);
			geom_q.off_y <= 8'((9'(OUT_HEIGHT) - fh) >> 1);
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign geom = geom_q;

endmodule

>>> hw/rtl/lrq_map.sv
// Address pipeline: output pixel to source raster address, write beats pass through
`timescale 1ns / 1ps
module lrq_map import lrq_pkg::*; #(
	parameter int unsigned OUT_WIDTH      = 96,
	parameter int unsigned OUT_HEIGHT     = 96,
	parameter int unsigned MAX_SRC_WIDTH  = 320,
	parameter int unsigned MAX_SRC_HEIGHT = 240
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_vld,
	input  item_t item,
	input  geom_t geom,
	output acc_t  acc
);

	localparam int unsigned DEPTH   = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int unsigned OUT_PIX = OUT_WIDTH * OUT_HEIGHT;
	localparam int unsigned IDX_MUL = ((1 << IDX_SHIFT) + OUT_WIDTH - 1) / OUT_WIDTH;
	localparam int unsigned MUL_W   = ((1 << SCL_SHIFT) + OUT_WIDTH - 1) / OUT_WIDTH;
	localparam int unsigned MUL_H   = ((1 << SCL_SHIFT) + OUT_HEIGHT - 1) / OUT_HEIGHT;

	typedef struct packed {
		logic        cmd;
		logic [16:0] waddr;
		logic [15:0] wdata;
	} ctl_t;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic [13:0] idx_s1;
	logic [7:0]  row_s1, row_s2;
	logic        inr_s1, inr_s2;
	logic [7:0]  col_s2;
	logic        pad_s3, pad_s4, pad_s5, pad_s6;
	logic [7:0]  dy_s3, dx_s3;
	logic [16:0] py_s4, px_s4;
	logic [13:0] sy_s5, sx_s5;
	logic [16:0] raddr_s6;

	logic [35:0] idx_prod;
	logic [15:0] col_c;
	logic        in_y, in_x;
	logic [25:0] msel;
	logic [42:0] prod_y, prod_x;
	logic [7:0]  sy_cl;
	logic [8:0]  sx_cl;
	logic [16:0] raddr;

	assign idx_prod = 36'(item.out_index) * 36'(IDX_MUL);
	assign col_c    = 16'(idx_s1) - 16'(row_s1) * 16'(OUT_WIDTH);

	always_comb begin
		in_y = (row_s2 >= geom.off_y) && ({1'b0, row_s2} < 9'(geom.off_y) + geom.fit_h);
		in_x = (col_s2 >= geom.off_x) && ({1'b0, col_s2} < 9'(geom.off_x) + geom.fit_w);
	end

	assign msel   = geom.sel_h ? 26'(MUL_H) : 26'(MUL_W);
	assign prod_y = 43'(py_s4) * 43'(msel);
	assign prod_x = 43'(px_s4) * 43'(msel);

	always_comb begin
		sy_cl = (sy_s5 >= 14'(geom.h)) ? geom.h - 8'd1 : sy_s5[7:0];
		sx_cl = (sx_s5 >= 14'(geom.w)) ? geom.w - 9'd1 : sx_s5[8:0];
		raddr = 17'(sy_cl) * 17'(geom.w) + 17'(sx_cl);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= '{cmd: item.command, waddr: item.src_address, wdata: item.pixel_value};
			idx_s1 <= item.out_index;
			row_s1 <= idx_prod[IDX_SHIFT+7:IDX_SHIFT];
			inr_s1 <= 32'(item.out_index) < OUT_PIX;

			ctl_s2 <= ctl_s1;
			row_s2 <= row_s1;
			col_s2 <= col_c[7:0];
			inr_s2 <= inr_s1;

			ctl_s3 <= ctl_s2;
			pad_s3 <= !(inr_s2 && in_y && in_x);
			dy_s3  <= row_s2 - geom.off_y;
			dx_s3  <= col_s2 - geom.off_x;

			ctl_s4 <= ctl_s3;
			pad_s4 <= pad_s3;
			py_s4  <= 17'(dy_s3) * 17'(geom.den);
			px_s4  <= 17'(dx_s3) * 17'(geom.den);

			ctl_s5 <= ctl_s4;
			pad_s5 <= pad_s4;
			sy_s5  <= prod_y[SCL_SHIFT+13:SCL_SHIFT];
			sx_s5  <= prod_x[SCL_SHIFT+13:SCL_SHIFT];

			ctl_s6   <= ctl_s5;
			pad_s6   <= pad_s5;
			raddr_s6 <= raddr;
		end
	end

	// drop writes beyond the store
	assign acc.vld   = v_s6 && (ctl_s6.cmd || (32'(ctl_s6.waddr) < DEPTH));
	assign acc.wr    = !ctl_s6.cmd;
	assign acc.pad   = pad_s6;
	assign acc.addr  = ctl_s6.cmd ? raddr_s6 : ctl_s6.waddr;
	assign acc.wdata = ctl_s6.wdata;

endmodule

>>> hw/rtl/lrq_store.sv
// Frame store: single-port synchronous memory of RGB565 source pixels
`timescale 1ns / 1ps
module lrq_store import lrq_pkg::*; #(
	parameter int unsigned DEPTH = 76800
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  acc_t acc,
	output rd_t  rd
);

	localparam int unsigned AW = $clog2(DEPTH);

	logic [15:0]   mem [DEPTH];
	logic [AW-1:0] a;
	logic [15:0]   pix_s7;
	logic          v_s7;
	logic          pad_s7;

	assign a = AW'(acc.addr);

	always_ff @(posedge clk) begin
		if (en) begin
			if (acc.vld && acc.wr) begin
				mem[a] <= acc.wdata;
			end
			pix_s7 <= mem[a];
			pad_s7 <= acc.pad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= acc.vld && !acc.wr;
		end
	end

	assign rd = '{vld: v_s7, pad: pad_s7, pix: pix_s7};

endmodule

>>> hw/rtl/lrq_quant.sv
// Quantizer: widen RGB565, scale by the gain, round half away, add zero point, saturate
`timescale 1ns / 1ps
module lrq_quant import lrq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  rd_t               rd,
	input  logic [23:0]       gain,
	input  logic signed [7:0] zp,
	output logic              res_vld,
	output result_t           res
);

	logic        v_s8;
	logic        pad_s8;
	logic        neg_s8 [3];
	logic [31:0] mag_s8 [3];

	logic [7:0]        p   [3];
	logic [7:0]        a   [3];
	logic [32:0]       sum [3];
	logic signed [17:0] sv [3];
	logic signed [17:0] v  [3];
	logic signed [7:0]  q  [3];

	always_comb begin
		p[0] = {rd.pix[15:11], 3'b000};
		p[1] = {rd.pix[10:5], 2'b00};
		p[2] = {rd.pix[4:0], 3'b000};
		for (int i = 0; i < 3; i++) begin
			if (rd.pad) begin
				p[i] = '0;
			end
			// |2p - 255|, sign taken from the top bit
			a[i] = p[i][7] ? {p[i][6:0], 1'b1} : ~{p[i][6:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= rd.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pad_s8 <= rd.pad;
			for (int i = 0; i < 3; i++) begin
				neg_s8[i] <= !p[i][7];
				mag_s8[i] <= 32'(a[i]) * 32'(gain);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = 33'(mag_s8[i]) + ROUND_BIAS;
			sv[i]  = neg_s8[i] ? -$signed({2'b00, sum[i][32:17]})
				: $signed({2'b00, sum[i][32:17]});
			v[i]   = sv[i] + 18'(zp);
			if (v[i] < -18'sd128) begin
				q[i] = -8'sd128;
			end else if (v[i] > 18'sd127) begin
				q[i] = 8'sd127;
			end else begin
				q[i] = v[i][7:0];
			end
		end
	end

	assign res_vld        = v_s8;
	assign res.red_q      = q[0];
	assign res.green_q    = q[1];
	assign res.blue_q     = q[2];
	assign res.is_padding = pad_s8;

endmodule

>>> hw/rtl/lrq_checker.sv
// Port-level checker for the letterbox resize and quantize block, with its bind
`timescale 1ns / 1ps
`include "letterbox_resize_quantize_top_assert.svh"
module lrq_checker import lrq_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input result_t     result,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [3:0]  paddr,
	input logic        pready
);

	`LRQ_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result beat dropped or changed while stalled")
	`LRQ_ASSERT_NOW(a_pad_black, result_valid && result.is_padding, result.red_q == result.green_q && result.green_q == result.blue_q, "padding beat is not uniform black")
	`LRQ_ASSERT_NEXT(a_size_refit, psel && penable && pwrite && pready && (paddr[3:2] == REG_SRC_WIDTH || paddr[3:2] == REG_SRC_HEIGHT), !item_ready, "items taken while the fit is recomputed")

endmodule

bind letterbox_resize_quantize_top lrq_checker u_lrq_checker (.*);

>>> verif/letterbox_resize_quantize_top_test.sv
// Self-checking testbench for the letterbox resize and quantize block
`timescale 1ns / 1ps
module letterbox_resize_quantize_top_test;
	import lrq_pkg::*;

	localparam int unsigned OUT_W      = 96;
	localparam int unsigned OUT_H      = 96;
	localparam int unsigned MAX_W      = 320;
	localparam int unsigned MAX_H      = 240;
	localparam int unsigned STORE_SIZE = MAX_W * MAX_H;
	localparam int unsigned OUT_PIXELS = OUT_W * OUT_H;
	// cycles with no beat on any port before the run is declared hung
	localparam int unsigned HANG_LIMIT = 3000;
	// pipe depth plus skid and fit-unit recompute, with margin
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned PHASES = 10;

	// Tracks the frame store and the registers, predicts each output pixel and
	// checks results against the predictions in beat order.
	class pixel_scoreboard;
		logic [15:0]     store [STORE_SIZE];
		bit              written [STORE_SIZE];
		logic [8:0]      width_reg  = SRC_WIDTH_RST;
		logic [7:0]      height_reg = SRC_HEIGHT_RST;
		logic [23:0]     gain_reg   = QUANT_GAIN_RST;
		logic signed [7:0] zero_reg = ZERO_OFFSET_RST;
		result_t         pixel_q [$];
		int              errors = 0;

		function void set_reg(reg_idx_t idx, logic [31:0] val);
			case (idx)
				REG_SRC_WIDTH: width_reg = val[8:0];
				REG_SRC_HEIGHT: height_reg = val[7:0];
				REG_QUANT_GAIN: gain_reg = val[23:0];
				REG_ZERO_OFFSET: zero_reg = val[7:0];
			endcase
		endfunction

		// map an output index to its source address, or flag it as padding
		function void locate(int unsigned idx, output bit pad, output int unsigned addr);
			int unsigned w, h, num, den, fw, fh, ox, oy, row, col, sx, sy;
			w = width_reg;
			h = height_reg;
			if (w < 1) w = 1;
			if (w > MAX_W) w = MAX_W;
			if (h < 1) h = 1;
			if (h > MAX_H) h = MAX_H;
			if (OUT_W * h <= OUT_H * w) begin
				num = OUT_W;
				den = w;
			end else begin
				num = OUT_H;
				den = h;
			end
			fw = w * num / den;
			fh = h * num / den;
			if (fw > OUT_W) fw = OUT_W;
			if (fh > OUT_H) fh = OUT_H;
			ox = (OUT_W - fw) / 2;
			oy = (OUT_H - fh) / 2;
			pad = 1'b1;
			addr = 0;
			if (idx < OUT_PIXELS) begin
				row = idx / OUT_W;
				col = idx % OUT_W;
				if (row >= oy && row < oy + fh && col >= ox && col < ox + fw) begin
					sy = (row - oy) * den / num;
					sx = (col - ox) * den / num;
					if (sy >= h) sy = h - 1;
					if (sx >= w) sx = w - 1;
					addr = sy * w + sx;
					pad = 1'b0;
				end
			end
		endfunction

		function logic signed [7:0] quantize(int unsigned p);
			longint centered, prod, mag, rounded, q;
			centered = 2 * longint'(p) - 255;
			prod = centered * longint'(gain_reg);
			mag = (prod < 0) ? -prod : prod;
			rounded = (mag + 65536) >>> 17;
			q = ((prod < 0) ? -rounded : rounded) + longint'(zero_reg);
			if (q < -128) q = -128;
			if (q > 127) q = 127;
			return q[7:0];
		endfunction

		function result_t predict_pixel(item_t it);
			result_t     res;
			bit          pad;
			int unsigned addr, r, g, b;
			logic [15:0] c;
			locate(it.out_index, pad, addr);
			c = pad ? 16'h0 : store[addr];
			r = {c[15:11], 3'b0};
			g = {c[10:5], 2'b0};
			b = {c[4:0], 3'b0};
			res.red_q = quantize(r);
			res.green_q = quantize(g);
			res.blue_q = quantize(b);
			res.is_padding = pad;
			return res;
		endfunction

		task note_item(item_t it);
			if (!it.command) begin
				// writes past the store are dropped by the block
				if (it.src_address < STORE_SIZE) begin
					store[it.src_address] = it.pixel_value;
					written[it.src_address] = 1'b1;
				end
			end else
				pixel_q.push_back(predict_pixel(it));
		endtask

		task report(string what);
			$display("MISMATCH at %0t: %s", $time, what);
			errors++;
		endtask

		task check_pixel(result_t got);
			result_t want;
			if (pixel_q.size() == 0) begin
				report($sformatf("unexpected result %h", got));
				return;
			end
			want = pixel_q.pop_front();
			if (got.red_q !== want.red_q)
				report($sformatf("red_q %0d, want %0d", got.red_q, want.red_q));
			if (got.green_q !== want.green_q)
				report($sformatf("green_q %0d, want %0d", got.green_q, want.green_q));
			if (got.blue_q !== want.blue_q)
				report($sformatf("blue_q %0d, want %0d", got.blue_q, want.blue_q));
			if (got.is_padding !== want.is_padding)
				report($sformatf("is_padding %0b, want %0b", got.is_padding,
					want.is_padding));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	pixel_scoreboard pixels = new();
	bit          quiet = 1'b0;	// no idling on either side while set
	int unsigned hang_count = 0;

	letterbox_resize_quantize_top uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// Receiver: unless quiet, stall at random about 7 percent of the time.
	always @(negedge clk) begin
		if (arst_n)
			result_ready <= quiet || ($urandom_range(99) >= 7);
	end

	// Sample result beats at the rising edge and check them.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			pixels.check_pixel(result);
	end

	// Hang detector: count cycles with no beat on any port.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) ||
			(psel && penable) || !arst_n)
			hang_count <= 0;
		else if (hang_count >= HANG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else
			hang_count <= hang_count + 1;
	end

	// Drive one item beat; hold valid and payload until taken.
	task send_item(item_t it);
		while (!quiet && $urandom_range(99) < 7) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		pixels.note_item(it);
		@(negedge clk);
	endtask

	task write_pixel(int unsigned addr, logic [15:0] val);
		item_t it;
		it = '0;
		it.command = 1'b0;
		it.src_address = addr;
		it.pixel_value = val;
		it.out_index = $urandom_range(16383);
		send_item(it);
	endtask

	// Read an output pixel, first loading its source sample if never written.
	task read_pixel(int unsigned idx);
		item_t       it;
		bit          pad;
		int unsigned addr;
		pixels.locate(idx, pad, addr);
		if (!pad && !pixels.written[addr])
			write_pixel(addr, $urandom_range(65535));
		it = '0;
		it.command = 1'b1;
		it.src_address = $urandom_range(131071);
		it.pixel_value = $urandom_range(65535);
		it.out_index = idx;
		send_item(it);
	endtask

	// Setup and access cycle of one write; the caller closes the transfer.
	task write_reg(reg_idx_t idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pixels.set_reg(idx, val);
		@(negedge clk);
	endtask

	task configure(logic [8:0] w, logic [7:0] h, logic [23:0] g, logic [7:0] z);
		write_reg(REG_SRC_WIDTH, {23'b0, w});
		write_reg(REG_SRC_HEIGHT, {24'b0, h});
		write_reg(REG_QUANT_GAIN, {8'b0, g});
		write_reg(REG_ZERO_OFFSET, {24'b0, z});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Wait until every predicted pixel has come back, then let the pipe settle.
	task drain;
		item_valid <= 1'b0;
		while (pixels.pixel_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Mixed random traffic: mostly reads in range, with writes anywhere.
	task random_traffic(int unsigned count);
		int unsigned sel;
		repeat (count) begin
			sel = $urandom_range(99);
			if (sel < 55)
				read_pixel($urandom_range(OUT_PIXELS - 1));
			else if (sel < 60)
				read_pixel($urandom_range(16383, OUT_PIXELS));
			else if (sel < 92)
				write_pixel($urandom_range(STORE_SIZE - 1), $urandom_range(65535));
			else
				write_pixel($urandom_range(131071), $urandom_range(65535));
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed pass on the reset registers: store extremes, dropped writes,
		// corner, centre and out-of-range output pixels.
		write_pixel(0, 16'hFFFF);
		write_pixel(STORE_SIZE - 1, 16'h0000);
		write_pixel(STORE_SIZE, 16'hFFFF);
		write_pixel(131071, 16'hAAAA);
		write_pixel(MAX_W * 12, 16'hF800);
		read_pixel(0);
		read_pixel(OUT_W * 12);
		read_pixel(OUT_W * 12 + OUT_W - 1);
		read_pixel(OUT_W * 48 + 48);
		read_pixel(OUT_W * 83 + 95);
		read_pixel(OUT_W * 84);
		read_pixel(OUT_PIXELS - 1);
		read_pixel(OUT_PIXELS);
		read_pixel(16383);
		write_pixel(OUT_W, 16'h07E0);
		write_pixel(1, 16'h001F);
		drain();

		// Register extremes, out-of-range source sizes, then random settings.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: configure(9'd1, 8'd1, 24'd0, 8'h80);
				1: configure(9'd320, 8'd240, 24'hFFFFFF, 8'h7F);
				2: configure(9'd0, 8'd0, 24'd65793, 8'h00);
				3: configure(9'd511, 8'd255, 24'd131072, 8'hFB);
				4: configure(9'd1, 8'd240, $urandom_range(24'hFFFFFF), $urandom_range(255));
				5: configure(9'd320, 8'd1, $urandom_range(24'hFFFFFF), $urandom_range(255));
				default: configure($urandom_range(1, 48), $urandom_range(1, 48),
					$urandom_range(24'hFFFFFF), $urandom_range(255));
			endcase
			quiet = (p == 6);
			random_traffic(170);
			drain();
			quiet = 1'b0;
		end

		if (pixels.pixel_q.size() != 0)
			pixels.report("results missing at end");
		if (pixels.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
